// ===== hw/rtl/i2c_teb_pkg.sv =====
// Shared types, constants and codes for the I2C target event buffer.
package i2c_teb_pkg;

    // Receive ring buffer geometry.
    localparam int RX_DEPTH = 64;
    localparam int RX_IDX_W = $clog2(RX_DEPTH);

    // Send register geometry: four bytes, indexed by a 2-bit pointer.
    localparam int TX_DEPTH = 4;
    localparam int TX_IDX_W = 2;
    localparam int SEND_W   = 32;

    // Command codes.
    localparam logic [1:0] CMD_EVENT = 2'd0;
    localparam logic [1:0] CMD_FETCH = 2'd1;
    localparam logic [1:0] CMD_ARM   = 2'd2;

    // Bus event codes.
    localparam logic [2:0] EV_READ_ACK   = 3'd0;
    localparam logic [2:0] EV_DATA_NACK  = 3'd1;
    localparam logic [2:0] EV_WRITE_ACK  = 3'd2;
    localparam logic [2:0] EV_DATA_RX    = 3'd3;
    localparam logic [2:0] EV_STOP       = 3'd4;
    localparam logic [2:0] EV_ERROR      = 3'd5;
    localparam logic [2:0] EV_UNKNOWN    = 3'd6;

    // One request on the input channel.
    typedef struct packed {
        logic [1:0] command;
        logic [2:0] event_kind;
        logic [7:0] rx_byte;
    } in_item_t;

    // One result on the output channel.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic [7:0] fetched_byte;
        logic       fetch_valid;
        logic       overflow_signal;
        logic       release_with_stop;
        logic       busy_res;
        logic       data_available;
        logic       buffer_is_full;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/i2c_target_event_buffer.sv =====
// Top level of the I2C target event buffer: controller, datapath and checks.
//
//  Channel  | Signals                          | Handshake
//  ---------+----------------------------------+----------------------------
//  input    | in_valid, in_ready, in_data      | valid/ready, one request
//  output   | out_valid, out_ready, out_data   | valid/ready, one result
//  config   | cfg_we, cfg_wdata                | write enable, no wait
//
// Each request is captured, then executed: the accept cycle reads the receive
// memory at the read pointer; the execute state runs it and loads the output
// register once free. The single read port of the 64-entry memory sets this.
// Reset clears pointers, flags, the send register and the output valid; the
// memory needs no clearing. A result waiting in the output register does not
// block acceptance; only a second result with the register still full stalls.
module i2c_target_event_buffer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  i2c_teb_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output i2c_teb_pkg::out_item_t out_data
);
    import i2c_teb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller.
    i2c_teb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    i2c_teb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // An accepted request blocks the next accept until it has executed.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another was executing");

    // Capture and execute never coincide.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");

    // A dropped byte only happens with the buffer full.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.overflow_signal && !out_data.buffer_is_full))
        else $error("overflow reported with buffer not full");

    // A full buffer always reports data available.
    a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.buffer_is_full && !out_data.data_available))
        else $error("full buffer reported without data");

endmodule

// ===== hw/rtl/i2c_teb_ctrl.sv =====
// Controller state machine: sequences capture and execute of each request.
module i2c_teb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  i2c_teb_pkg::dp_status_t status,
    output i2c_teb_pkg::dp_cmd_t    cmd
);
    import i2c_teb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Requests are taken only when no earlier request is still executing.
    assign in_ready    = (state_reg == ST_IDLE);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.execute = (state_reg == ST_EXEC) && status.out_free;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/i2c_teb_datapath.sv =====
// Datapath: receive memory, ring pointers, send register, flags, result register.
module i2c_teb_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    input  i2c_teb_pkg::in_item_t  in_data,
    input  i2c_teb_pkg::dp_cmd_t   cmd,
    output i2c_teb_pkg::dp_status_t status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output i2c_teb_pkg::out_item_t out_data
);
    import i2c_teb_pkg::*;

    localparam logic [RX_IDX_W-1:0] RX_LAST = RX_IDX_W'(RX_DEPTH - 1);
    localparam logic [TX_IDX_W-1:0] TX_LAST = TX_IDX_W'(TX_DEPTH - 1);

    logic [7:0]          mem [RX_DEPTH];
    logic [7:0]          rd_data_reg;
    in_item_t            item_reg;
    logic [SEND_W-1:0]   send_bytes_reg;
    logic [RX_IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [RX_IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic                full_reg, full_next;
    logic [TX_IDX_W-1:0] send_idx_reg, send_idx_next;
    logic                busy_reg, busy_next;
    logic                out_valid_reg;
    out_item_t           out_data_reg;
    out_item_t           result;
    logic                mem_we;
    logic                has_data;

    assign has_data        = full_reg || (wr_idx_reg != rd_idx_reg);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    // Execute one request: next pointer and flag values plus the result.
    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        full_next     = full_reg;
        send_idx_next = send_idx_reg;
        busy_next     = busy_reg;
        mem_we        = 1'b0;
        result        = '0;
        unique case (item_reg.command)
            CMD_EVENT:
            begin
                unique case (item_reg.event_kind)
                    EV_READ_ACK:
                    begin
                        result.tx_byte = send_bytes_reg[send_idx_reg*8 +: 8];
                        send_idx_next  = (send_idx_reg == TX_LAST) ? '0
                                       : TX_IDX_W'(send_idx_reg + 1'b1);
                        busy_next      = 1'b1;
                    end
                    EV_WRITE_ACK:
                    begin
                        busy_next = 1'b1;
                    end
                    EV_DATA_RX:
                    begin
                        if (full_reg)
                        begin
                            result.overflow_signal = 1'b1;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            wr_idx_next = (wr_idx_reg == RX_LAST) ? '0
                                        : RX_IDX_W'(wr_idx_reg + 1'b1);
                            full_next   = (wr_idx_next == rd_idx_reg);
                        end
                        busy_next = 1'b1;
                    end
                    EV_ERROR:
                    begin
                        result.release_with_stop = 1'b1;
                    end
                    default:
                    begin
                        // Data NACK, stop, unknown and unused codes end the transfer.
                        busy_next = 1'b0;
                    end
                endcase
            end
            CMD_FETCH:
            begin
                if (has_data)
                begin
                    result.fetched_byte = rd_data_reg;
                    result.fetch_valid  = 1'b1;
                    rd_idx_next         = (rd_idx_reg == RX_LAST) ? '0
                                        : RX_IDX_W'(rd_idx_reg + 1'b1);
                    full_next           = 1'b0;
                end
            end
            CMD_ARM:
            begin
                send_idx_next = '0;
                busy_next     = 1'b1;
            end
            default:
            begin
                // Unused command: status only.
            end
        endcase
        result.busy_res       = busy_next;
        result.data_available = full_next || (wr_idx_next != rd_idx_next);
        result.buffer_is_full = full_next;
    end

    // Receive memory: write on execute, registered read at capture.
    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_we)
            mem[wr_idx_reg] <= item_reg.rx_byte;
        if (cmd.capture)
            rd_data_reg <= mem[rd_idx_reg];
    end

    // Captured request and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.execute)
            out_data_reg <= result;
    end

    // Send register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            send_bytes_reg <= '0;
        else if (cfg_we)
            send_bytes_reg <= cfg_wdata;
    end

    // Pointers, flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            full_reg      <= 1'b0;
            send_idx_reg  <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                wr_idx_reg   <= wr_idx_next;
                rd_idx_reg   <= rd_idx_next;
                full_reg     <= full_next;
                send_idx_reg <= send_idx_next;
                busy_reg     <= busy_next;
            end
            if (cmd.execute)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== tb/i2c_target_event_buffer_tb.sv =====
// Testbench for the I2C target event buffer: directed and random requests checked by a predictor.
`timescale 1ns / 100ps

module i2c_target_event_buffer_tb;

    import i2c_teb_pkg::*;

    // Codes the package does not name: an unused command and an out-of-range event.
    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam logic [2:0] EV_RESERVED = 3'd7;

    // Cycles allowed after the last result before the block counts as idle.
    localparam int DRAIN_CYCLES = 6;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int MAX_REPORTS  = 10;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Handshake pressure, in percent of cycles spent idle or stalled.
    int send_idle_pct = 21;
    int recv_idle_pct = 70;

    // Predicted state of the block.
    logic [7:0]          rx_mem [RX_DEPTH];
    logic [RX_IDX_W-1:0] rx_wr    = '0;
    logic [RX_IDX_W-1:0] rx_rd    = '0;
    logic                rx_full  = 1'b0;
    logic [TX_IDX_W-1:0] tx_ptr   = '0;
    logic                bus_busy = 1'b0;
    logic [SEND_W-1:0]   send_reg = '0;

    // Results predicted but not yet seen on the output.
    out_item_t expected_results [$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int requests_sent  = 0;
    int bytes_fetched  = 0;
    int bytes_dropped  = 0;
    int full_reports   = 0;
    int cfg_writes     = 0;

    i2c_target_event_buffer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver side: stall at random according to the current pressure.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Work out the result of one request and advance the predicted state.
    function automatic out_item_t predict_result(in_item_t req);
        out_item_t res;
        res = '0;
        case (req.command)
            CMD_EVENT:
            begin
                case (req.event_kind)
                    EV_READ_ACK:
                    begin
                        res.tx_byte = send_reg[8*tx_ptr +: 8];
                        tx_ptr = (tx_ptr == TX_DEPTH - 1) ? '0 : tx_ptr + 1'b1;
                        bus_busy = 1'b1;
                    end
                    EV_WRITE_ACK:
                    begin
                        bus_busy = 1'b1;
                    end
                    EV_DATA_RX:
                    begin
                        if (rx_full)
                        begin
                            res.overflow_signal = 1'b1;
                        end
                        else
                        begin
                            rx_mem[rx_wr] = req.rx_byte;
                            rx_wr = (rx_wr == RX_DEPTH - 1) ? '0 : rx_wr + 1'b1;
                            if (rx_wr == rx_rd)
                            begin
                                rx_full = 1'b1;
                            end
                        end
                        bus_busy = 1'b1;
                    end
                    EV_ERROR:
                    begin
                        res.release_with_stop = 1'b1;
                    end
                    default:
                    begin
                        // Data NACK, stop, unknown and the reserved code all end the transfer.
                        bus_busy = 1'b0;
                    end
                endcase
            end
            CMD_FETCH:
            begin
                // A full buffer holds data even though the pointers are equal.
                if (rx_full || (rx_wr != rx_rd))
                begin
                    res.fetched_byte = rx_mem[rx_rd];
                    res.fetch_valid = 1'b1;
                    rx_rd = (rx_rd == RX_DEPTH - 1) ? '0 : rx_rd + 1'b1;
                    rx_full = 1'b0;
                end
            end
            CMD_ARM:
            begin
                tx_ptr = '0;
                bus_busy = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.busy_res = bus_busy;
        res.data_available = rx_full || (rx_wr != rx_rd);
        res.buffer_is_full = rx_full;
        return res;
    endfunction

    // Offer one request, wait for it to be taken, then record its expected result.
    task automatic send_request(input logic [1:0] cmd, input logic [2:0] kind,
                                input logic [7:0] data);
        in_item_t  req;
        out_item_t res;
        req.command = cmd;
        req.event_kind = kind;
        req.rx_byte = data;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        res = predict_result(req);
        expected_results.push_back(res);
        if (cmd != CMD_NONE)
        begin
            requests_sent++;
        end
        bytes_fetched += res.fetch_valid;
        bytes_dropped += res.overflow_signal;
        full_reports += res.buffer_is_full;
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Load the send register while the block is idle.
    task automatic write_send_bytes(input logic [31:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        send_reg = value;
        cfg_writes++;
    endtask

    // Read events walk through all four send bytes, wrap, and restart after arm.
    task automatic test_send_rotation();
        write_send_bytes(32'h80FF_0100);
        repeat (5) send_request(CMD_EVENT, EV_READ_ACK, 8'($urandom));
        send_request(CMD_ARM, 3'($urandom), 8'($urandom));
        send_request(CMD_EVENT, EV_READ_ACK, 8'($urandom));
        send_request(CMD_EVENT, EV_DATA_NACK, 8'($urandom));
    endtask

    // Store and fetch the extreme byte values, including a fetch from empty.
    task automatic test_receive_path();
        send_request(CMD_FETCH, EV_READ_ACK, 8'h00);
        send_request(CMD_EVENT, EV_WRITE_ACK, 8'h00);
        send_request(CMD_EVENT, EV_DATA_RX, 8'h00);
        send_request(CMD_EVENT, EV_DATA_RX, 8'hFF);
        repeat (3) send_request(CMD_FETCH, 3'($urandom), 8'($urandom));
        send_request(CMD_EVENT, EV_STOP, 8'hFF);
    endtask

    // Error, unknown and reserved events, the unused command, and arm while busy.
    task automatic test_misc_events();
        send_request(CMD_EVENT, EV_ERROR, 8'($urandom));
        send_request(CMD_EVENT, EV_WRITE_ACK, 8'($urandom));
        send_request(CMD_EVENT, EV_UNKNOWN, 8'($urandom));
        send_request(CMD_EVENT, EV_WRITE_ACK, 8'($urandom));
        send_request(CMD_EVENT, EV_RESERVED, 8'($urandom));
        send_request(CMD_NONE, EV_RESERVED, 8'hFF);
        send_request(CMD_NONE, EV_READ_ACK, 8'h00);
        send_request(CMD_EVENT, EV_READ_ACK, 8'($urandom));
        send_request(CMD_ARM, 3'($urandom), 8'($urandom));
        send_request(CMD_EVENT, EV_ERROR, 8'($urandom));
    endtask

    // Fill the buffer, overflow it, free one slot, refill, then drain it past empty.
    task automatic test_fill_and_overflow();
        int i;
        write_send_bytes(32'hFFFF_FFFF);
        send_request(CMD_EVENT, EV_WRITE_ACK, 8'($urandom));
        for (i = 0; i < RX_DEPTH; i++)
        begin
            send_request(CMD_EVENT, EV_DATA_RX, 8'($urandom));
        end
        repeat (2) send_request(CMD_EVENT, EV_DATA_RX, 8'($urandom));
        send_request(CMD_ARM, 3'($urandom), 8'($urandom));
        send_request(CMD_EVENT, EV_READ_ACK, 8'($urandom));
        send_request(CMD_FETCH, 3'($urandom), 8'($urandom));
        send_request(CMD_EVENT, EV_DATA_RX, 8'($urandom));
        send_request(CMD_EVENT, EV_DATA_RX, 8'($urandom));
        for (i = 0; i <= RX_DEPTH; i++)
        begin
            send_request(CMD_FETCH, 3'($urandom), 8'($urandom));
        end
        send_request(CMD_EVENT, EV_STOP, 8'($urandom));
    endtask

    // Bus transactions with random content, main-side fetches and some noise.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count, input logic [31:0] send_value);
        int goal;
        int pick;
        int burst;
        write_send_bytes(send_value);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = requests_sent + count;
        while (requests_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                // Write transfer; an occasional long burst can drive the buffer to full.
                send_request(CMD_EVENT, EV_WRITE_ACK, 8'($urandom));
                burst = ($urandom_range(9) == 0) ? $urandom_range(30, 70)
                                                 : $urandom_range(1, 6);
                repeat (burst) send_request(CMD_EVENT, EV_DATA_RX, 8'($urandom));
                send_request(CMD_EVENT, ($urandom_range(7) == 0) ? EV_ERROR : EV_STOP,
                             8'($urandom));
            end
            else if (pick < 60)
            begin
                repeat ($urandom_range(1, 16))
                    send_request(CMD_FETCH, 3'($urandom), 8'($urandom));
            end
            else if (pick < 85)
            begin
                // Read transfer, sometimes armed first, ended by NACK and stop.
                if ($urandom_range(1) != 0)
                begin
                    send_request(CMD_ARM, 3'($urandom), 8'($urandom));
                end
                repeat ($urandom_range(1, 7))
                    send_request(CMD_EVENT, EV_READ_ACK, 8'($urandom));
                send_request(CMD_EVENT, EV_DATA_NACK, 8'($urandom));
                send_request(CMD_EVENT, EV_STOP, 8'($urandom));
            end
            else
            begin
                send_request(2'($urandom), 3'($urandom), 8'($urandom));
            end
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("unexpected result %0d: %h", results_seen, out_data);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if ((out_data.tx_byte !== want.tx_byte)
                    || (out_data.fetched_byte !== want.fetched_byte)
                    || (out_data.fetch_valid !== want.fetch_valid)
                    || (out_data.overflow_signal !== want.overflow_signal)
                    || (out_data.release_with_stop !== want.release_with_stop)
                    || (out_data.busy_res !== want.busy_res)
                    || (out_data.data_available !== want.data_available)
                    || (out_data.buffer_is_full !== want.buffer_is_full))
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("result %0d wrong (expected/actual): tx %h/%h fetched %h/%h %s",
                                 results_seen, want.tx_byte, out_data.tx_byte,
                                 want.fetched_byte, out_data.fetched_byte, "flags below");
                        $display("  valid %b/%b ovf %b/%b rel %b/%b busy %b/%b avail %b/%b full %b/%b",
                                 want.fetch_valid, out_data.fetch_valid,
                                 want.overflow_signal, out_data.overflow_signal,
                                 want.release_with_stop, out_data.release_with_stop,
                                 want.busy_res, out_data.busy_res,
                                 want.data_available, out_data.data_available,
                                 want.buffer_is_full, out_data.buffer_is_full);
                    end
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_send_rotation();
        test_receive_path();
        test_misc_events();
        test_fill_and_overflow();
        test_random_traffic(21, 70, 340, $urandom);
        test_random_traffic(70, 21, 340, 32'h0000_0000);
        test_random_traffic(0, 0, 340, $urandom);
        drain_results();
        $display("Covered %0d requests and %0d results under three stall mixes, %0d send settings.",
                 requests_sent, results_seen, cfg_writes);
        $display("Fetched %0d bytes, dropped %0d on overflow, full status on %0d results.",
                 bytes_fetched, bytes_dropped, full_reports);
        if ((mismatch_count == 0) && (expected_results.size() == 0))
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
